@@ rtl/core/rmf_pkg.sv @@
package rmf_pkg;

  // window_length register
  localparam int unsigned WL_W = 6;
  localparam logic [WL_W-1:0] WL_RESET = 6'd3;

  // controller to datapath
  typedef struct packed {
    logic take;       // latch the accepted item, write it to the ring
    logic rd_issue;   // read one earlier sample from the ring
    logic div_start;  // launch the divider on the finished sum
    logic load;       // move the quotient to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_done;    // no earlier samples left to read
    logic div_done;   // quotient ready
    logic out_free;   // output register empty or being emptied
  } status_t;

endpackage

@@ rtl/core/rmf_if.sv @@
// Sample channel
interface rmf_sample_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;
  logic                start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink (input valid, input sample, input start_req, output ready);
endinterface

// Result channel
interface rmf_mean_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] mean;

  modport source (output valid, output mean, input ready);
  modport sink (input valid, input mean, output ready);
endinterface

// Configuration write channel
interface rmf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rmf_pkg::WL_W-1:0]    window_length;

  modport source (output valid, output window_length, input ready);
  modport sink (input valid, input window_length, output ready);
endinterface

@@ rtl/core/rmf_div.sv @@
// Restoring divider, one quotient bit per cycle
module rmf_div #(
  parameter int unsigned DW = 22,
  parameter int unsigned VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] dvs;
  logic [VW:0]   rem_sh;
  logic          fits;

  // one trial subtraction
  always_comb begin
    rem_sh = {rem, quo[DW-1]};
    fits   = (rem_sh >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? VW'(rem_sh - {1'b0, dvs}) : rem_sh[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/core/rmf_ctrl.sv @@
// Sequencer: accept, read the window, divide, hand over the result
module rmf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rmf_pkg::status_t status,
  output rmf_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (status.rd_done) begin
          state_next = S_DRAIN;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one item in flight at a time
  a_take_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> !in_ready)
    else $error("second item accepted while busy");

  // divider finishes only while being waited for
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_DIV))
    else $error("divider done outside divide phase");

  // reads and division never overlap
  a_read_before_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> $past(status.rd_done))
    else $error("divider started before window read finished");

endmodule

@@ rtl/core/rmf_datapath.sv @@
// Ring of samples, window accumulator, divider and output register
module rmf_datapath #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rmf_pkg::cmd_t                  cmd,
  output rmf_pkg::status_t               status,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           start_req,
  input  logic                           cfg_we,
  input  logic [rmf_pkg::WL_W-1:0]       cfg_window_length,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic signed [SAMPLE_WIDTH-1:0] mean
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam int unsigned SUM_W = SAMPLE_WIDTH + PTR_W;
  localparam int unsigned MW    = (PTR_W > rmf_pkg::WL_W) ? PTR_W : rmf_pkg::WL_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [rmf_pkg::WL_W-1:0]       window_length;
  logic [PTR_W-1:0]               fill_count;
  logic [PTR_W-1:0]               write_pointer;
  logic [PTR_W-1:0]               rd_ptr;
  logic [PTR_W-1:0]               remain;
  logic [PTR_W-1:0]               n_used;
  logic                           rd_valid;
  logic signed [SAMPLE_WIDTH-1:0] rd_data;
  logic signed [SUM_W-1:0]        running_sum;
  logic                           neg;
  logic [SAMPLE_WIDTH-1:0]        mem [DEPTH];

  logic [PTR_W-1:0]               fill_eff;
  logic [MW-1:0]                  fill_w;
  logic [MW-1:0]                  wl_w;
  logic [PTR_W-1:0]               n_take;
  logic [SUM_W-1:0]               magnitude;
  logic [SUM_W-1:0]               quotient;
  logic [SUM_W-1:0]               q_signed;
  logic                           div_done;

  // window size of the accepted item
  always_comb begin
    fill_eff = start_req ? '0 : fill_count;
    fill_w   = MW'(fill_eff);
    wl_w     = MW'(window_length);
    n_take   = (fill_w < wl_w) ? fill_eff : PTR_W'(window_length);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= rmf_pkg::WL_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_window_length;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      write_pointer <= '0;
      remain        <= '0;
      rd_valid      <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_issue;
      if (cmd.take) begin
        fill_count    <= (fill_eff < LAST) ? fill_eff + 1'b1 : fill_eff;
        write_pointer <= (write_pointer == LAST) ? '0 : write_pointer + 1'b1;
        remain        <= n_take;
      end else if (cmd.rd_issue) begin
        remain <= remain - 1'b1;
      end
      if (cmd.load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // read pointer walks back from the newest earlier sample
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_ptr <= (write_pointer == '0) ? LAST : write_pointer - 1'b1;
      n_used <= n_take;
    end else if (cmd.rd_issue) begin
      rd_ptr <= (rd_ptr == '0) ? LAST : rd_ptr - 1'b1;
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[write_pointer] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // window accumulator
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      running_sum <= SUM_W'(sample);
    end else if (rd_valid) begin
      running_sum <= running_sum + SUM_W'(rd_data);
    end
  end

  // divide the magnitude, restore the sign after
  assign magnitude = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : running_sum;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= running_sum[SUM_W-1];
    end
  end

  rmf_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (magnitude),
    .divisor  ({1'b0, n_used} + CNT_W'(1)),
    .quotient (quotient),
    .done     (div_done)
  );

  assign q_signed = neg ? SUM_W'(-quotient) : quotient;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mean <= q_signed[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    status.rd_done  = (remain == '0);
    status.div_done = div_done;
    status.out_free = !res_valid || res_ready;
  end

  // a loaded result is offered in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> res_valid)
    else $error("result not presented after load");

  // ring reads stay within the window
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (remain != '0) && (remain <= n_used))
    else $error("ring read outside the window");

endmodule

@@ rtl/core/rolling_mean_filter.sv @@
// An accepted item passes the ring walk over n, the number of earlier samples averaged,
//   then the divider over SUM_W = SAMPLE_WIDTH + log2(DEPTH) (22) bits, to result valid.
// Only one item is in flight at a time: the one-read-per-cycle ring walk, the bit-serial
//   divider and the load of the result finish before the next item is accepted.
// Reset (synchronous, active high): window_length 3, fill count and write pointer
//   zero, no result pending; the sample ring is not cleared.
module rolling_mean_filter #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  rmf_sample_if.sink        sample_ch,
  rmf_mean_if.source        mean_ch,
  rmf_cfg_if.sink           cfg
);

  rmf_pkg::cmd_t    cmd;
  rmf_pkg::status_t status;

  // window length is only sampled when an item is taken, so writes are always accepted
  assign cfg.ready = 1'b1;

  rmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (sample_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rmf_datapath #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .sample            (sample_ch.sample),
    .start_req         (sample_ch.start_req),
    .cfg_we            (cfg.valid && cfg.ready),
    .cfg_window_length (cfg.window_length),
    .res_valid         (mean_ch.valid),
    .res_ready         (mean_ch.ready),
    .mean              (mean_ch.mean)
  );

endmodule
